// ===== rtl/core/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_PING  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_FRAG      = 3'd1;
   localparam logic [2:0] ERR_FRAME_BIG = 3'd2;
   localparam logic [2:0] ERR_MSG_BIG   = 3'd3;
   localparam logic [2:0] ERR_OPCODE    = 3'd4;

   // Size limit register
   localparam int unsigned   LEN_W     = 27;
   localparam logic [26:0]   MAX_RESET = 27'd67108864;

   // One parsed result, with a valid flag
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic        has_byte;
      logic [7:0]  data_byte;
      logic        last;
      logic [2:0]  error_code;
   } rsp_type;

endpackage

// ===== rtl/core/wsd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame parse state and its combinational update for one received byte.
// ----------------------------------------------------------------------------
module wsd_parser
   import wsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data,
   input  logic                step_en,
   input  logic [7:0]          rx_byte,
   output rsp_type             result,
   output logic                halted
);

   // Parse phases
   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_HALT    = 3'd5;

   // Opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   logic [2:0]        phase_ff, phase_in;
   logic              fin_ff, fin_in;
   logic [3:0]        opcode_ff, opcode_in;
   logic              masked_ff, masked_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              len_ovf_ff, len_ovf_in;   // length has bits above 27
   logic [3:0]        cnt_ff, cnt_in;
   logic [31:0]       key_ff, key_in;
   logic [1:0]        pos_ff, pos_in;
   logic              frag_open_ff, frag_open_in;
   logic [LEN_W-1:0]  msg_bytes_ff, msg_bytes_in;
   logic [LEN_W-1:0]  max_ff;

   logic [LEN_W-1:0]  len_cur;
   logic              ovf_cur;
   logic              masked_cur;
   logic              len_done;
   logic              hdr_end;
   logic              too_large;
   logic [LEN_W:0]    msg_sum;
   logic              msg_large;
   logic              is_data_op;
   logic [LEN_W-1:0]  len_dec;
   logic              pay_end;
   logic [7:0]        key_byte;
   logic [7:0]        pay_data;
   rsp_type           res;

   assign halted = (phase_ff == PH_HALT);

   // Key byte for the current mask position, first key byte first
   always_comb begin
      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign pay_data   = rx_byte ^ key_byte;
   assign len_dec    = len_ff - LEN_W'(1);
   assign pay_end    = (len_dec == '0);
   assign is_data_op = (opcode_ff == OP_BINARY) || (opcode_ff == OP_CONT);

   // Header checks on the length as updated by this byte
   assign too_large = ovf_cur || (len_cur > max_ff);
   assign msg_sum   = {1'b0, msg_bytes_ff} + {1'b0, len_cur};
   assign msg_large = msg_sum > {1'b0, max_ff};

   // Next state and result
   always_comb begin
      phase_in     = phase_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      len_in       = len_ff;
      len_ovf_in   = len_ovf_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      frag_open_in = frag_open_ff;
      msg_bytes_in = msg_bytes_ff;
      len_cur      = len_ff;
      ovf_cur      = len_ovf_ff;
      masked_cur   = masked_ff;
      len_done     = 1'b0;
      hdr_end      = 1'b0;
      res          = '0;

      case (phase_ff)
         PH_HDR0: begin
            fin_in    = rx_byte[7];
            opcode_in = rx_byte[3:0];
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            masked_cur = rx_byte[7];
            masked_in  = rx_byte[7];
            if ((rx_byte[6:0] == LEN7_EXT16) || (rx_byte[6:0] == LEN7_EXT64)) begin
               cnt_in     = (rx_byte[6:0] == LEN7_EXT16) ? 4'd2 : 4'd8;
               len_in     = '0;
               len_ovf_in = 1'b0;
               phase_in   = PH_EXTLEN;
            end else begin
               len_cur    = LEN_W'(rx_byte[6:0]);
               ovf_cur    = 1'b0;
               len_in     = len_cur;
               len_ovf_in = 1'b0;
               len_done   = 1'b1;
            end
         end
         PH_EXTLEN: begin
            // big-endian shift; bits pushed past 27 only set the overflow flag
            len_cur    = {len_ff[LEN_W-9:0], rx_byte};
            ovf_cur    = len_ovf_ff || (len_ff[LEN_W-1:LEN_W-8] != '0);
            len_in     = len_cur;
            len_ovf_in = ovf_cur;
            cnt_in     = cnt_ff - 4'd1;
            len_done   = (cnt_ff == 4'd1);
         end
         PH_KEY: begin
            key_in  = {key_ff[23:0], rx_byte};
            cnt_in  = cnt_ff - 4'd1;
            hdr_end = (cnt_ff == 4'd1);
         end
         PH_PAYLOAD: begin
            if (len_ff == '0) begin
               phase_in = PH_HDR0;
            end else begin
               pos_in = pos_ff + 2'd1;
               len_in = len_dec;
               if (pay_end) begin
                  phase_in = PH_HDR0;
               end
               res.has_byte  = 1'b1;
               res.data_byte = pay_data;
               if (is_data_op) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_DATA;
                  if (pay_end && fin_ff) begin
                     frag_open_in = 1'b0;
                     msg_bytes_in = '0;
                     res.last     = 1'b1;
                  end
               end else if (opcode_ff == OP_PING) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_PING;
                  res.last  = pay_end;
               end else if (opcode_ff == OP_CLOSE) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_CLOSE;
                  res.last  = pay_end;
                  if (pay_end) begin
                     phase_in = PH_HALT;
                  end
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // Length complete: fetch the key or finish the header
      if (len_done) begin
         key_in = '0;
         if (masked_cur) begin
            cnt_in   = 4'd4;
            phase_in = PH_KEY;
         end else begin
            hdr_end = 1'b1;
         end
      end

      // Header end checks
      if (hdr_end) begin
         pos_in = 2'd0;
         if (too_large) begin
            phase_in       = PH_HALT;
            res.valid      = 1'b1;
            res.last       = 1'b1;
            res.error_code = ERR_FRAME_BIG;
         end else if (is_data_op) begin
            if ((opcode_ff == OP_BINARY) == frag_open_ff) begin
               phase_in       = PH_HALT;
               res.valid      = 1'b1;
               res.last       = 1'b1;
               res.error_code = ERR_FRAG;
            end else if (msg_large) begin
               phase_in       = PH_HALT;
               res.valid      = 1'b1;
               res.last       = 1'b1;
               res.error_code = ERR_MSG_BIG;
            end else begin
               msg_bytes_in = msg_sum[LEN_W-1:0];
               frag_open_in = 1'b1;
               if (len_cur != '0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_HDR0;
                  if (fin_ff) begin
                     frag_open_in = 1'b0;
                     msg_bytes_in = '0;
                     res.valid    = 1'b1;
                     res.kind     = KIND_DATA;
                     res.last     = 1'b1;
                  end
               end
            end
         end else if ((opcode_ff == OP_PING) || (opcode_ff == OP_PONG)
                      || (opcode_ff == OP_CLOSE)) begin
            if (len_cur != '0) begin
               phase_in = PH_PAYLOAD;
            end else if (opcode_ff == OP_PONG) begin
               phase_in = PH_HDR0;
            end else if (opcode_ff == OP_PING) begin
               phase_in  = PH_HDR0;
               res.valid = 1'b1;
               res.kind  = KIND_PING;
               res.last  = 1'b1;
            end else begin
               phase_in  = PH_HALT;
               res.valid = 1'b1;
               res.kind  = KIND_CLOSE;
               res.last  = 1'b1;
            end
         end else begin
            phase_in       = PH_HALT;
            res.valid      = 1'b1;
            res.last       = 1'b1;
            res.error_code = ERR_OPCODE;
         end
      end
   end

   always_comb begin
      result       = res;
      result.valid = res.valid && step_en;
   end

   // State registers, updated once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         fin_ff       <= 1'b0;
         opcode_ff    <= 4'h0;
         masked_ff    <= 1'b0;
         len_ff       <= '0;
         len_ovf_ff   <= 1'b0;
         cnt_ff       <= 4'd0;
         key_ff       <= '0;
         pos_ff       <= 2'd0;
         frag_open_ff <= 1'b0;
         msg_bytes_ff <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
         len_ff       <= len_in;
         len_ovf_ff   <= len_ovf_in;
         cnt_ff       <= cnt_in;
         key_ff       <= key_in;
         pos_ff       <= pos_in;
         frag_open_ff <= frag_open_in;
         msg_bytes_ff <= msg_bytes_in;
      end
   end

   // Size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// A byte is held in the input register, parsed, and its result beat registered.
// One byte per cycle unless the result stalls; parse state updates once per byte.
// The input register advances whenever the result register is free or being read.
// Reset: synchronous, active high; parser returns to the first header byte,
// the size limit returns to 64 MiB and both register stages are emptied.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Byte-serial websocket frame header parser and payload unmasker.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // size limit register
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data,
   // received byte stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,    // [7:0] rx_byte
   // parsed result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,    // [7:0] data_byte, [10:8] error_code
   output logic [2:0]          rsp_tuser,    // [1:0] kind, [2] has_byte
   output logic                rsp_tlast     // last
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     parse_res;
   logic        advance;
   logic        step_en;
   logic        parse_halted;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (step_en),
      .rx_byte     (in_byte_ff),
      .result      (parse_res),
      .halted      (parse_halted)
   );

   // Result register
   assign rsp_valid_in = advance ? parse_res.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= parse_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.error_code, rsp_ff.data_byte};
   assign rsp_tuser  = {rsp_ff.has_byte, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.last;

`ifndef SYNTHESIS
   // A full input register facing a stalled result must back-pressure
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while pipeline stalled");

   // Once halted, the parser stays halted until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      parse_halted |=> parse_halted)
      else $error("parser left halt without reset");

   // Error beats carry no byte and end the stream
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:8] != ERR_NONE) |-> rsp_tlast && !rsp_tuser[2]
         && (rsp_tuser[1:0] == KIND_DATA))
      else $error("malformed error beat");

   // Beats without a byte carry zero data
   a_bare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> (rsp_tdata[7:0] == 8'd0))
      else $error("bare beat carries data");
`endif

endmodule
